// ===== sv/ilt_pkg.sv =====
// Package for the indexed list table: request codes, field widths and
// default sizes. Used by indexed_list_table; depends on nothing else.
package ilt_pkg;

	typedef enum logic [2:0] {
		FN_APPEND     = 3'd0,
		FN_INSERT     = 3'd1,
		FN_SET        = 3'd2,
		FN_REMOVE_AT  = 3'd3,
		FN_REMOVE_VAL = 3'd4,
		FN_FIND       = 3'd5,
		FN_READ       = 3'd6,
		FN_CLEAR      = 3'd7
	} func_t;

	localparam int DEF_ENTRIES    = 256;
	localparam int DEF_VALUE_BITS = 32;

	localparam int FUNC_W  = 3;
	localparam int POS_W   = 9;
	localparam int ITEM_W  = 32;
	localparam int FPOS_W  = 8;
	localparam int COUNT_W = 9;

endpackage

// ===== sv/indexed_list_table.sv =====
// Indexed list table: ordered list in a memory with one write and one registered read port,
// scanned one entry per cycle by a single sequencer around one value comparator.
// A new request is taken only after the response to the last one has been registered;
// set, clear and rejected requests go straight to the response, read waits for the memory
// read, and insert, remove at, remove value and find first scan the entries moved or compared.
// A held response stalls the next request. Reset clears the fill count and handshake state, not
// the memory content. Depends on ilt_pkg.
module indexed_list_table #(
	parameter int ENTRIES    = ilt_pkg::DEF_ENTRIES,
	parameter int VALUE_BITS = ilt_pkg::DEF_VALUE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [ilt_pkg::FUNC_W-1:0]  func,
	input  logic [ilt_pkg::POS_W-1:0]   position,
	input  logic [ilt_pkg::ITEM_W-1:0]  item_value,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [ilt_pkg::ITEM_W-1:0]  read_value,
	output logic [ilt_pkg::FPOS_W-1:0]  found_position,
	output logic                        found,
	output logic                        status,
	output logic [ilt_pkg::COUNT_W-1:0] length_after,
	output logic [ilt_pkg::COUNT_W-1:0] removed_count
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > ilt_pkg::POS_W) ? CNT_W : ilt_pkg::POS_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT_UP,
		ST_SHIFT_DOWN,
		ST_COMPACT,
		ST_SEARCH,
		ST_READ_WAIT,
		ST_FINISH
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        fill_q;
	logic [CNT_W-1:0]        ptr_q;
	logic [CNT_W-1:0]        pos_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [VALUE_BITS-1:0]   val_q;

	logic [ilt_pkg::ITEM_W-1:0] res_read_q;
	logic [IDX_W-1:0]           res_fpos_q;
	logic                       res_found_q;
	logic                       res_status_q;
	logic [CNT_W-1:0]           res_removed_q;

	logic                        rsp_valid_q;
	logic [ilt_pkg::ITEM_W-1:0]  read_value_q;
	logic [ilt_pkg::FPOS_W-1:0]  found_position_q;
	logic                        found_q;
	logic                        status_q;
	logic [ilt_pkg::COUNT_W-1:0] length_after_q;
	logic [ilt_pkg::COUNT_W-1:0] removed_count_q;

	logic [VALUE_BITS-1:0] mem [ENTRIES];
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [VALUE_BITS-1:0] mem_wdata;
	logic [IDX_W-1:0]      mem_raddr;
	logic [VALUE_BITS-1:0] rdata_s1;
	logic                  vld_s1;
	logic [IDX_W-1:0]      addr_s1;

	logic                  issue;
	logic                  eq;
	logic [VALUE_BITS-1:0] val_in;
	logic [CMP_W-1:0]      pos_ext;
	logic [CMP_W-1:0]      fill_ext;
	logic [CMP_W-1:0]      ins_ext;
	ilt_pkg::func_t        fn;

	assign fn       = ilt_pkg::func_t'(func);
	assign val_in   = VALUE_BITS'(item_value);
	assign pos_ext  = CMP_W'(position);
	assign fill_ext = CMP_W'(fill_q);
	assign ins_ext  = (fn == ilt_pkg::FN_APPEND) ? fill_ext : pos_ext;
	assign eq       = (rdata_s1 == val_q);

	assign req_ready      = (state_q == ST_IDLE);
	assign rsp_valid      = rsp_valid_q;
	assign read_value     = read_value_q;
	assign found_position = found_position_q;
	assign found          = found_q;
	assign status         = status_q;
	assign length_after   = length_after_q;
	assign removed_count  = removed_count_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = rdata_s1;
		mem_raddr = IDX_W'(position);
		issue     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && fn == ilt_pkg::FN_SET && pos_ext < fill_ext) begin
					mem_we    = 1'b1;
					mem_waddr = IDX_W'(position);
					mem_wdata = val_in;
				end
			end
			ST_SHIFT_UP: begin
				if (ptr_q > pos_q) begin
					issue     = 1'b1;
					mem_raddr = IDX_W'(ptr_q - CNT_W'(1));
				end
				if (vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = addr_s1 + IDX_W'(1);
				end else if (ptr_q == pos_q) begin
					mem_we    = 1'b1;
					mem_waddr = IDX_W'(pos_q);
					mem_wdata = val_q;
				end
			end
			ST_SHIFT_DOWN: begin
				if (ptr_q < fill_q) begin
					issue     = 1'b1;
					mem_raddr = IDX_W'(ptr_q);
				end
				if (vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = addr_s1 - IDX_W'(1);
				end
			end
			ST_COMPACT: begin
				if (ptr_q < fill_q) begin
					issue     = 1'b1;
					mem_raddr = IDX_W'(ptr_q);
				end
				if (vld_s1 && !eq) begin
					mem_we    = 1'b1;
					mem_waddr = addr_s1 - IDX_W'(cnt_q);
				end
			end
			ST_SEARCH: begin
				if (ptr_q < fill_q && !(vld_s1 && eq)) begin
					issue     = 1'b1;
					mem_raddr = IDX_W'(ptr_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			addr_s1 <= '0;
		end else begin
			vld_s1  <= issue;
			addr_s1 <= mem_raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			fill_q           <= '0;
			ptr_q            <= '0;
			pos_q            <= '0;
			cnt_q            <= '0;
			val_q            <= '0;
			res_read_q       <= '0;
			res_fpos_q       <= '0;
			res_found_q      <= 1'b0;
			res_status_q     <= 1'b0;
			res_removed_q    <= '0;
			rsp_valid_q      <= 1'b0;
			read_value_q     <= '0;
			found_position_q <= '0;
			found_q          <= 1'b0;
			status_q         <= 1'b0;
			length_after_q   <= '0;
			removed_count_q  <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && state_q != ST_FINISH) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						val_q       <= val_in;
						cnt_q       <= '0;
						res_read_q  <= '0;
						res_fpos_q  <= '0;
						res_found_q <= 1'b0;
						case (fn)
							ilt_pkg::FN_APPEND, ilt_pkg::FN_INSERT: begin
								res_removed_q <= '0;
								if (fill_ext >= CMP_W'(ENTRIES) || ins_ext > fill_ext) begin
									res_status_q <= 1'b1;
									state_q      <= ST_FINISH;
								end else begin
									res_status_q <= 1'b0;
									pos_q        <= CNT_W'(ins_ext);
									ptr_q        <= fill_q;
									state_q      <= ST_SHIFT_UP;
								end
							end
							ilt_pkg::FN_SET: begin
								res_status_q  <= (pos_ext >= fill_ext);
								res_removed_q <= '0;
								state_q       <= ST_FINISH;
							end
							ilt_pkg::FN_REMOVE_AT: begin
								res_removed_q <= '0;
								if (pos_ext >= fill_ext) begin
									res_status_q <= 1'b1;
									state_q      <= ST_FINISH;
								end else begin
									res_status_q <= 1'b0;
									ptr_q        <= CNT_W'(pos_ext) + CNT_W'(1);
									state_q      <= ST_SHIFT_DOWN;
								end
							end
							ilt_pkg::FN_REMOVE_VAL: begin
								res_status_q  <= 1'b0;
								res_removed_q <= '0;
								ptr_q         <= '0;
								state_q       <= ST_COMPACT;
							end
							ilt_pkg::FN_FIND: begin
								res_status_q  <= 1'b0;
								res_removed_q <= '0;
								ptr_q         <= '0;
								state_q       <= ST_SEARCH;
							end
							ilt_pkg::FN_READ: begin
								res_removed_q <= '0;
								if (pos_ext >= fill_ext) begin
									res_status_q <= 1'b1;
									state_q      <= ST_FINISH;
								end else begin
									res_status_q <= 1'b0;
									state_q      <= ST_READ_WAIT;
								end
							end
							default: begin
								res_status_q  <= 1'b0;
								res_removed_q <= fill_q;
								fill_q        <= '0;
								state_q       <= ST_FINISH;
							end
						endcase
					end
				end
				ST_SHIFT_UP: begin
					if (issue) begin
						ptr_q <= ptr_q - CNT_W'(1);
					end
					if (!vld_s1 && ptr_q == pos_q) begin
						fill_q  <= fill_q + CNT_W'(1);
						state_q <= ST_FINISH;
					end
				end
				ST_SHIFT_DOWN: begin
					if (issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (!vld_s1 && ptr_q >= fill_q) begin
						fill_q        <= fill_q - CNT_W'(1);
						res_removed_q <= CNT_W'(1);
						state_q       <= ST_FINISH;
					end
				end
				ST_COMPACT: begin
					if (issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (vld_s1 && eq) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (!vld_s1 && ptr_q >= fill_q) begin
						fill_q        <= fill_q - cnt_q;
						res_removed_q <= cnt_q;
						state_q       <= ST_FINISH;
					end
				end
				ST_SEARCH: begin
					if (issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (vld_s1 && eq) begin
						res_found_q <= 1'b1;
						res_fpos_q  <= addr_s1;
						state_q     <= ST_FINISH;
					end else if (!vld_s1 && ptr_q >= fill_q) begin
						state_q <= ST_FINISH;
					end
				end
				ST_READ_WAIT: begin
					res_read_q <= ilt_pkg::ITEM_W'(rdata_s1);
					state_q    <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q      <= 1'b1;
						read_value_q     <= res_read_q;
						found_position_q <= ilt_pkg::FPOS_W'(res_fpos_q);
						found_q          <= res_found_q;
						status_q         <= res_status_q;
						length_after_q   <= ilt_pkg::COUNT_W'(fill_q);
						removed_count_q  <= ilt_pkg::COUNT_W'(res_removed_q);
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(ENTRIES))
		else $error("Fill count exceeds the list capacity.");

	a_write_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CNT_W'(mem_waddr) <= fill_q))
		else $error("Memory write lands beyond the end of the list.");

	a_grow_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q > $past(fill_q)) |-> ($past(state_q) == ST_SHIFT_UP))
		else $error("Fill count grew outside an insert.");

	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_SHIFT_UP || state_q == ST_SHIFT_DOWN ||
			state_q == ST_COMPACT || state_q == ST_SEARCH || state_q == ST_FINISH))
		else $error("Read pipeline active outside a scan.");
`endif

endmodule

// ===== bench/tb_indexed_list_table.sv =====
`timescale 1ns / 1ps
// Self-checking bench for indexed_list_table: a directed table followed by random
// phases that grow, shrink and churn the list; a shadow list predicts each untyped response.
// Depends on ilt_pkg and indexed_list_table.
module tb_indexed_list_table;

	localparam int LIST_DEPTH = ilt_pkg::DEF_ENTRIES;
	localparam logic ST_DONE = 1'b0;
	localparam logic ST_REJECT = 1'b1;

	typedef struct packed {
		ilt_pkg::func_t fn;
		logic [ilt_pkg::POS_W-1:0] pos;
		logic [ilt_pkg::ITEM_W-1:0] val;
	} list_req_t;

	typedef struct packed {
		logic [ilt_pkg::ITEM_W-1:0] rd;
		logic [ilt_pkg::FPOS_W-1:0] fpos;
		logic fnd;
		logic st;
		logic [ilt_pkg::COUNT_W-1:0] len;
		logic [ilt_pkg::COUNT_W-1:0] rem;
	} list_rsp_t;

	typedef struct packed {
		list_req_t req;
		logic typed;
		list_rsp_t rsp;
	} dir_step_t;

	typedef enum int {PROF_GROW, PROF_SHRINK, PROF_MIXED} profile_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	logic [ilt_pkg::FUNC_W-1:0] func;
	logic [ilt_pkg::POS_W-1:0] position;
	logic [ilt_pkg::ITEM_W-1:0] item_value;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [ilt_pkg::ITEM_W-1:0] read_value;
	logic [ilt_pkg::FPOS_W-1:0] found_position;
	logic found;
	logic status;
	logic [ilt_pkg::COUNT_W-1:0] length_after;
	logic [ilt_pkg::COUNT_W-1:0] removed_count;

	logic [ilt_pkg::ITEM_W-1:0] shadow_entries [0:LIST_DEPTH-1];
	int shadow_fill = 0;
	list_rsp_t pending_rsp [$];
	dir_step_t dir_steps [$];

	int n_err = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_rejected = 0;
	int n_at_full = 0;
	int ack_hold = 0;
	bit stall_enable = 1'b1;

	indexed_list_table u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.func(func),
		.position(position),
		.item_value(item_value),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.read_value(read_value),
		.found_position(found_position),
		.found(found),
		.status(status),
		.length_after(length_after),
		.removed_count(removed_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic list_rsp_t list_apply(input list_req_t r);
		list_rsp_t o;
		int i;
		int k;
		int p;
		o = '0;
		o.st = ST_DONE;
		case (r.fn)
			ilt_pkg::FN_APPEND, ilt_pkg::FN_INSERT: begin
				p = (r.fn == ilt_pkg::FN_APPEND) ? shadow_fill : int'(r.pos);
				if (shadow_fill >= LIST_DEPTH || p > shadow_fill) begin
					o.st = ST_REJECT;
				end else begin
					for (i = shadow_fill; i > p; i--) shadow_entries[i] = shadow_entries[i - 1];
					shadow_entries[p] = r.val;
					shadow_fill++;
				end
			end
			ilt_pkg::FN_SET: begin
				if (int'(r.pos) >= shadow_fill) o.st = ST_REJECT;
				else shadow_entries[int'(r.pos)] = r.val;
			end
			ilt_pkg::FN_REMOVE_AT: begin
				if (int'(r.pos) >= shadow_fill) begin
					o.st = ST_REJECT;
				end else begin
					for (i = int'(r.pos) + 1; i < shadow_fill; i++)
						shadow_entries[i - 1] = shadow_entries[i];
					shadow_fill--;
					o.rem = 1;
				end
			end
			ilt_pkg::FN_REMOVE_VAL: begin
				k = 0;
				for (i = 0; i < shadow_fill; i++) begin
					if (shadow_entries[i] == r.val) k++;
					else shadow_entries[i - k] = shadow_entries[i];
				end
				shadow_fill -= k;
				o.rem = ilt_pkg::COUNT_W'(k);
			end
			ilt_pkg::FN_FIND: begin
				for (i = 0; i < shadow_fill; i++) begin
					if (!o.fnd && shadow_entries[i] == r.val) begin
						o.fnd = 1'b1;
						o.fpos = ilt_pkg::FPOS_W'(i);
					end
				end
			end
			ilt_pkg::FN_READ: begin
				if (int'(r.pos) >= shadow_fill) o.st = ST_REJECT;
				else o.rd = shadow_entries[int'(r.pos)];
			end
			default: begin
				o.rem = ilt_pkg::COUNT_W'(shadow_fill);
				shadow_fill = 0;
			end
		endcase
		o.len = ilt_pkg::COUNT_W'(shadow_fill);
		return o;
	endfunction

	function automatic list_req_t pick_request(input profile_t prof);
		list_req_t r;
		int roll;
		int v;
		roll = $urandom_range(0, 99);
		case (prof)
			PROF_GROW: begin
				if (roll < 40) r.fn = ilt_pkg::FN_APPEND;
				else if (roll < 80) r.fn = ilt_pkg::FN_INSERT;
				else if (roll < 85) r.fn = ilt_pkg::FN_SET;
				else if (roll < 90) r.fn = ilt_pkg::FN_READ;
				else if (roll < 98) r.fn = ilt_pkg::FN_FIND;
				else r.fn = ilt_pkg::FN_REMOVE_AT;
			end
			PROF_SHRINK: begin
				if (roll < 30) r.fn = ilt_pkg::FN_REMOVE_AT;
				else if (roll < 55) r.fn = ilt_pkg::FN_REMOVE_VAL;
				else if (roll < 58) r.fn = ilt_pkg::FN_CLEAR;
				else if (roll < 70) r.fn = ilt_pkg::FN_FIND;
				else if (roll < 82) r.fn = ilt_pkg::FN_READ;
				else if (roll < 90) r.fn = ilt_pkg::FN_SET;
				else if (roll < 95) r.fn = ilt_pkg::FN_APPEND;
				else r.fn = ilt_pkg::FN_INSERT;
			end
			default: begin
				if (roll < 3) r.fn = ilt_pkg::FN_CLEAR;
				else r.fn = ilt_pkg::func_t'($urandom_range(0, 6));
			end
		endcase
		if ($urandom_range(0, 9) == 0) r.pos = ilt_pkg::POS_W'($urandom_range(0, 511));
		else r.pos = ilt_pkg::POS_W'($urandom_range(0, shadow_fill));
		roll = $urandom_range(0, 9);
		if ((r.fn == ilt_pkg::FN_FIND || r.fn == ilt_pkg::FN_REMOVE_VAL) && shadow_fill > 0 &&
				roll < 5) begin
			r.val = shadow_entries[$urandom_range(0, shadow_fill - 1)];
		end else if ($urandom_range(0, 9) < ((prof == PROF_GROW) ? 3 : 7)) begin
			v = $urandom_range(0, 5);
			if (v == 4) r.val = 32'hFFFF_FFFF;
			else if (v == 5) r.val = 32'h8000_0000;
			else r.val = ilt_pkg::ITEM_W'(v);
		end else begin
			r.val = $urandom;
		end
		return r;
	endfunction

	task automatic issue(input list_req_t r, input logic typed, input list_rsp_t typed_rsp);
		list_rsp_t calc;
		int gap;
		req_valid <= 1'b1;
		func <= r.fn;
		position <= r.pos;
		item_value <= r.val;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		calc = list_apply(r);
		pending_rsp.push_back(typed ? typed_rsp : calc);
		n_sent++;
		if (shadow_fill == LIST_DEPTH) n_at_full++;
		gap = 0;
		if (stall_enable && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 13);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			n_err++;
			if (n_err <= 200)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
		end
	endtask

	always @(posedge clk) begin
		list_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (status === ST_REJECT) n_rejected++;
			if (pending_rsp.size() == 0) begin
				n_err++;
				$display("%0t: response transfer with nothing outstanding, expected none, actual %h",
					$time, {read_value, found_position, found, status, length_after,
					removed_count});
			end else begin
				want = pending_rsp.pop_front();
				n_checked++;
				check_field("read_value", want.rd, read_value);
				check_field("found_position", 32'(want.fpos), 32'(found_position));
				check_field("found", 32'(want.fnd), 32'(found));
				check_field("status", 32'(want.st), 32'(status));
				check_field("length_after", 32'(want.len), 32'(length_after));
				check_field("removed_count", 32'(want.rem), 32'(removed_count));
			end
		end
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (ack_hold > 0) begin
			rsp_ready <= 1'b0;
			ack_hold--;
		end else if (stall_enable && $urandom_range(0, 19) == 0) begin
			rsp_ready <= 1'b0;
			ack_hold = $urandom_range(0, 12);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	initial begin
		int phase_len [12];
		profile_t phase_prof [12];
		int ph;
		int n;
		int n_dir;

		arst_n = 1'b0;
		req_valid = 1'b0;
		func = ilt_pkg::FN_APPEND;
		position = '0;
		item_value = '0;

		// Typed responses are given in this table; the rest use the shadow list.
		dir_steps.push_back('{'{ilt_pkg::FN_READ, 9'd0, 32'd0}, 1'b1,
			'{32'd0, 8'd0, 1'b0, ST_REJECT, 9'd0, 9'd0}});
		dir_steps.push_back('{'{ilt_pkg::FN_FIND, 9'd0, 32'd0}, 1'b1,
			'{32'd0, 8'd0, 1'b0, ST_DONE, 9'd0, 9'd0}});
		dir_steps.push_back('{'{ilt_pkg::FN_REMOVE_VAL, 9'd0, 32'd0}, 1'b1,
			'{32'd0, 8'd0, 1'b0, ST_DONE, 9'd0, 9'd0}});
		dir_steps.push_back('{'{ilt_pkg::FN_CLEAR, 9'd0, 32'd0}, 1'b1,
			'{32'd0, 8'd0, 1'b0, ST_DONE, 9'd0, 9'd0}});
		dir_steps.push_back('{'{ilt_pkg::FN_SET, 9'd0, 32'h1}, 1'b1,
			'{32'd0, 8'd0, 1'b0, ST_REJECT, 9'd0, 9'd0}});
		dir_steps.push_back('{'{ilt_pkg::FN_REMOVE_AT, 9'd0, 32'd0}, 1'b1,
			'{32'd0, 8'd0, 1'b0, ST_REJECT, 9'd0, 9'd0}});
		dir_steps.push_back('{'{ilt_pkg::FN_INSERT, 9'd1, 32'h5}, 1'b1,
			'{32'd0, 8'd0, 1'b0, ST_REJECT, 9'd0, 9'd0}});
		dir_steps.push_back('{'{ilt_pkg::FN_INSERT, 9'd0, 32'hFFFF_FFFF}, 1'b1,
			'{32'd0, 8'd0, 1'b0, ST_DONE, 9'd1, 9'd0}});
		dir_steps.push_back('{'{ilt_pkg::FN_APPEND, 9'd0, 32'd0}, 1'b1,
			'{32'd0, 8'd0, 1'b0, ST_DONE, 9'd2, 9'd0}});
		dir_steps.push_back('{'{ilt_pkg::FN_APPEND, 9'h1FF, 32'hFFFF_FFFF}, 1'b1,
			'{32'd0, 8'd0, 1'b0, ST_DONE, 9'd3, 9'd0}});
		dir_steps.push_back('{'{ilt_pkg::FN_INSERT, 9'd3, 32'h1}, 1'b1,
			'{32'd0, 8'd0, 1'b0, ST_DONE, 9'd4, 9'd0}});
		dir_steps.push_back('{'{ilt_pkg::FN_INSERT, 9'd1, 32'h1234_5678}, 1'b0, '0});
		dir_steps.push_back('{'{ilt_pkg::FN_READ, 9'd1, 32'd0}, 1'b0, '0});
		dir_steps.push_back('{'{ilt_pkg::FN_FIND, 9'd0, 32'hFFFF_FFFF}, 1'b1,
			'{32'd0, 8'd0, 1'b1, ST_DONE, 9'd5, 9'd0}});
		dir_steps.push_back('{'{ilt_pkg::FN_SET, 9'd4, 32'hA5A5_A5A5}, 1'b0, '0});
		dir_steps.push_back('{'{ilt_pkg::FN_READ, 9'h1FF, 32'd0}, 1'b1,
			'{32'd0, 8'd0, 1'b0, ST_REJECT, 9'd5, 9'd0}});
		dir_steps.push_back('{'{ilt_pkg::FN_SET, 9'd256, 32'h7}, 1'b1,
			'{32'd0, 8'd0, 1'b0, ST_REJECT, 9'd5, 9'd0}});
		dir_steps.push_back('{'{ilt_pkg::FN_REMOVE_AT, 9'd5, 32'd0}, 1'b1,
			'{32'd0, 8'd0, 1'b0, ST_REJECT, 9'd5, 9'd0}});
		dir_steps.push_back('{'{ilt_pkg::FN_INSERT, 9'd6, 32'h9}, 1'b1,
			'{32'd0, 8'd0, 1'b0, ST_REJECT, 9'd5, 9'd0}});
		dir_steps.push_back('{'{ilt_pkg::FN_REMOVE_VAL, 9'd0, 32'hFFFF_FFFF}, 1'b0, '0});
		dir_steps.push_back('{'{ilt_pkg::FN_FIND, 9'd0, 32'hDEAD_BEEF}, 1'b0, '0});
		dir_steps.push_back('{'{ilt_pkg::FN_REMOVE_AT, 9'd0, 32'd0}, 1'b0, '0});
		dir_steps.push_back('{'{ilt_pkg::FN_READ, 9'd0, 32'd0}, 1'b0, '0});
		dir_steps.push_back('{'{ilt_pkg::FN_CLEAR, 9'd0, 32'd0}, 1'b0, '0});
		dir_steps.push_back('{'{ilt_pkg::FN_READ, 9'd0, 32'd0}, 1'b1,
			'{32'd0, 8'd0, 1'b0, ST_REJECT, 9'd0, 9'd0}});

		phase_len = '{200, 200, 150, 150, 150, 200, 150, 150, 150, 150, 150, 150};
		phase_prof = '{PROF_GROW, PROF_GROW, PROF_MIXED, PROF_SHRINK, PROF_MIXED, PROF_GROW,
			PROF_SHRINK, PROF_MIXED, PROF_GROW, PROF_SHRINK, PROF_MIXED, PROF_GROW};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_steps[s]) issue(dir_steps[s].req, dir_steps[s].typed, dir_steps[s].rsp);
		n_dir = n_sent;

		for (ph = 0; ph < 12; ph++) begin
			stall_enable = (ph < 10) && (ph % 3 != 2);
			for (n = 0; n < phase_len[ph]; n++) issue(pick_request(phase_prof[ph]), 1'b0, '0);
			if (ph == 3) begin
				// Hold the request side until the block has drained completely.
				req_valid <= 1'b0;
				while (pending_rsp.size() != 0) @(posedge clk);
			end
		end

		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		$display("Run covered %0d requests (%0d directed) and %0d checked responses,",
			n_sent, n_dir, n_checked);
		$display("with %0d rejected and %0d transfers leaving the list full.",
			n_rejected, n_at_full);
		if (n_err == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
